// ===== hdl/rbs_pkg.sv =====
`default_nettype none

package rbs_pkg;

  localparam int NRANKS    = 64;
  localparam int PEND_W    = 64;
  localparam int TICK_W    = 32;
  localparam int CNT_W     = 7;
  localparam int RANK_W    = 8;
  localparam int QDEPTH    = 64;
  localparam int QA_W      = $clog2(QDEPTH);
  localparam int PCNT_W    = $clog2(QDEPTH + 1);
  localparam int SWEEP_W   = 8;
  localparam int SWEEP_N   = PEND_W / SWEEP_W;
  localparam int SWEEP_IW  = $clog2(SWEEP_N);
  localparam int CFG_IDX_W = 2;

  localparam logic [PEND_W-1:0] RANK_SPACE =
    (NRANKS >= PEND_W) ? {PEND_W{1'b1}} : ((PEND_W'(1) << NRANKS) - PEND_W'(1));

  localparam logic [CFG_IDX_W-1:0] CFG_MASK    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    FN_ENTER = 2'd0,
    FN_EXIT  = 2'd1,
    FN_TICK  = 2'd2,
    FN_ABORT = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    K_OK    = 3'd0,
    K_ERR   = 3'd1,
    K_REJ   = 3'd2,
    K_AFTER = 3'd3,
    K_TMO   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CNT,
    ST_RD,
    ST_WT
  } state_t;

  typedef struct packed {
    func_t             func;
    logic [RANK_W-1:0] rank;
  } in_t;

  typedef struct packed {
    kind_t             kind;
    logic [RANK_W-1:0] who;
    logic [PEND_W-1:0] pending_mask;
    logic [CNT_W-1:0]  pending_count;
    logic [CNT_W-1:0]  total_count;
    logic              last;
  } out_t;

  typedef struct packed {
    logic in_take;
    logic cfg_take;
    logic sweep;
    logic rd;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic need_drain;
    logic out_free;
    logic sweep_done;
    logic last_park;
  } stat_t;

  function automatic logic [3:0] popcount8(input logic [SWEEP_W-1:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < SWEEP_W; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rank_barrier_sync.sv =====
// channel | dir | handshake              | beat
// in      | in  | in_valid / in_ready    | in_data (func, rank)
// out     | out | out_valid / out_ready  | out_data (kind, who, masks, counts, last)
// cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// enter, tick and timeout writes are taken in the idle state; each result sits in one output register
// each released rank is a queue ram read, then the output load once the output register is free
// a participant mask write runs a popcount sweep over 8-bit slices with both ready lines low
// rst_n is synchronous, active low; no clearing pass, the queue is only read once written
// a beat waiting in the output register holds off every input beat until it is taken
`default_nettype none

module rank_barrier_sync
  import rbs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_t                      out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PEND_W-1:0]    cfg_data
);

  cmd_t  cmd;
  stat_t st;

  rbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .st        (st),
    .cmd       (cmd)
  );

  rbs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

`default_nettype wire

// ===== hdl/rbs_ram.sv =====
`default_nettype none

module rbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hdl/rbs_ctrl.sv =====
`default_nettype none

module rbs_ctrl
  import rbs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire stat_t                st,
  output cmd_t                      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.cfg_take && cfg_index == CFG_MASK) begin
          state_nxt = ST_CNT;
        end else if (cmd.in_take && st.need_drain) begin
          state_nxt = ST_RD;
        end
      end
      ST_CNT: begin
        if (st.sweep_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD: begin
        state_nxt = ST_WT;
      end
      ST_WT: begin
        if (st.out_free) begin
          state_nxt = st.last_park ? ST_IDLE : ST_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cfg_ready = 1'b0;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cfg_ready    = 1'b1;
        in_ready     = st.out_free && !cfg_valid;
        cmd.cfg_take = cfg_valid;
        cmd.in_take  = in_valid && st.out_free && !cfg_valid;
      end
      ST_CNT: begin
        cmd.sweep = 1'b1;
      end
      ST_RD: begin
        cmd.rd = 1'b1;
      end
      ST_WT: begin
        cmd.pop = st.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_drain_enters_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && cmd.in_take && st.need_drain) |=> cmd.rd)
    else $error("drain did not start with a queue read");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.in_take || cmd.cfg_take) |-> state_r == ST_IDLE)
    else $error("beat taken while busy");
  a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CNT) |-> (!in_ready && !cfg_ready))
    else $error("ready raised during the count sweep");
`endif

endmodule

`default_nettype wire

// ===== hdl/rbs_dp.sv =====
`default_nettype none

module rbs_dp
  import rbs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire in_t                  in_data,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PEND_W-1:0]    cfg_data,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output out_t                      out_data,
  input  wire cmd_t                 cmd,
  output stat_t                     st
);

  logic [PEND_W-1:0]   pend_r, pend_nxt;
  logic [CNT_W-1:0]    pcnt_r, pcnt_nxt;
  logic [CNT_W-1:0]    total_r, total_nxt;
  logic [CNT_W-1:0]    ent_r, ent_nxt;
  logic                exited_r, exited_nxt;
  logic [TICK_W-1:0]   ticks_r, ticks_nxt;
  logic                run_r, run_nxt;
  logic [TICK_W-1:0]   timeout_r, timeout_nxt;
  logic [QA_W-1:0]     head_r, head_nxt;
  logic [PCNT_W-1:0]   qcnt_r, qcnt_nxt;
  logic                rel_err_r, rel_err_nxt;
  logic [SWEEP_IW-1:0] sweep_r, sweep_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_r, out_nxt;

  logic                q_we;
  logic [QA_W-1:0]     q_rdata;
  logic                rank_ok;
  logic                need_drain;
  logic [CNT_W-1:0]    ent_inc;
  logic [TICK_W-1:0]   tick_dec;
  logic [CNT_W-1:0]    sweep_sum;

  assign rank_ok  = (in_data.rank < RANK_W'(NRANKS)) && pend_r[in_data.rank[QA_W-1:0]];
  assign ent_inc  = (ent_r == CNT_W'(QDEPTH)) ? ent_r : ent_r + CNT_W'(1);
  assign tick_dec = (ticks_r != '0) ? ticks_r - TICK_W'(1) : ticks_r;
  assign sweep_sum = pcnt_r + CNT_W'(popcount8(pend_r[sweep_r*SWEEP_W +: SWEEP_W]));

  assign st.need_drain = need_drain;
  assign st.out_free   = !out_valid_r || out_ready;
  assign st.sweep_done = (sweep_r == SWEEP_IW'(SWEEP_N - 1));
  assign st.last_park  = (qcnt_r == PCNT_W'(1));

  always_comb begin
    need_drain = 1'b0;
    unique case (in_data.func)
      FN_ENTER: need_drain = rank_ok && !exited_r && (ent_inc == total_r);
      FN_EXIT:  need_drain = (qcnt_r != '0);
      FN_TICK:  need_drain = 1'b0;
      FN_ABORT: need_drain = (qcnt_r != '0);
      default:  need_drain = 1'b0;
    endcase
  end

  always_comb begin
    pend_nxt      = pend_r;
    pcnt_nxt      = pcnt_r;
    total_nxt     = total_r;
    ent_nxt       = ent_r;
    exited_nxt    = exited_r;
    ticks_nxt     = ticks_r;
    run_nxt       = run_r;
    timeout_nxt   = timeout_r;
    head_nxt      = head_r;
    qcnt_nxt      = qcnt_r;
    rel_err_nxt   = rel_err_r;
    sweep_nxt     = sweep_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_we          = 1'b0;

    if (cmd.cfg_take) begin
      unique case (cfg_index)
        CFG_MASK: begin
          pend_nxt   = cfg_data & RANK_SPACE;
          pcnt_nxt   = '0;
          ent_nxt    = '0;
          head_nxt   = '0;
          qcnt_nxt   = '0;
          exited_nxt = 1'b0;
          ticks_nxt  = '0;
          run_nxt    = 1'b0;
          sweep_nxt  = '0;
        end
        CFG_TIMEOUT: timeout_nxt = cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end

    if (cmd.sweep) begin
      pcnt_nxt  = sweep_sum;
      sweep_nxt = sweep_r + SWEEP_IW'(1);
      if (st.sweep_done) begin
        total_nxt = sweep_sum;
      end
    end

    if (cmd.in_take) begin
      out_nxt.who           = in_data.rank;
      out_nxt.pending_mask  = pend_r;
      out_nxt.pending_count = pcnt_r;
      out_nxt.total_count   = total_r;
      out_nxt.last          = 1'b1;
      out_nxt.kind          = K_REJ;
      unique case (in_data.func)
        FN_ENTER: begin
          if (!rank_ok) begin
            out_valid_nxt = 1'b1;
          end else begin
            pend_nxt = pend_r & ~(PEND_W'(1) << in_data.rank[QA_W-1:0]);
            pcnt_nxt = pcnt_r - CNT_W'(1);
            ent_nxt  = ent_inc;
            if (exited_r) begin
              out_nxt.kind          = K_AFTER;
              out_nxt.pending_mask  = pend_nxt;
              out_nxt.pending_count = pcnt_nxt;
              out_valid_nxt         = 1'b1;
            end else begin
              if (qcnt_r != PCNT_W'(QDEPTH)) begin
                q_we     = 1'b1;
                qcnt_nxt = qcnt_r + PCNT_W'(1);
              end
              if (ent_inc == total_r) begin
                rel_err_nxt = 1'b0;
                run_nxt     = 1'b0;
                ticks_nxt   = '0;
              end else if (ent_inc == CNT_W'(1) && timeout_r != '0) begin
                ticks_nxt = timeout_r;
                run_nxt   = 1'b1;
              end
            end
          end
        end
        FN_EXIT: begin
          exited_nxt  = 1'b1;
          rel_err_nxt = 1'b1;
        end
        FN_TICK: begin
          if (run_r) begin
            ticks_nxt = tick_dec;
            if (tick_dec == '0) begin
              run_nxt       = 1'b0;
              out_nxt.kind  = K_TMO;
              out_nxt.who   = '0;
              out_valid_nxt = 1'b1;
            end
          end
        end
        FN_ABORT: begin
          rel_err_nxt = 1'b1;
          run_nxt     = 1'b0;
          ticks_nxt   = '0;
        end
        default: ;
      endcase
    end

    if (cmd.pop) begin
      out_nxt.kind          = rel_err_r ? K_ERR : K_OK;
      out_nxt.who           = RANK_W'(q_rdata);
      out_nxt.pending_mask  = pend_r;
      out_nxt.pending_count = pcnt_r;
      out_nxt.total_count   = total_r;
      out_nxt.last          = (qcnt_r == PCNT_W'(1));
      out_valid_nxt         = 1'b1;
      head_nxt              = head_r + QA_W'(1);
      qcnt_nxt              = qcnt_r - PCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      pcnt_r      <= '0;
      total_r     <= '0;
      ent_r       <= '0;
      exited_r    <= 1'b0;
      ticks_r     <= '0;
      run_r       <= 1'b0;
      timeout_r   <= '0;
      head_r      <= '0;
      qcnt_r      <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      pcnt_r      <= pcnt_nxt;
      total_r     <= total_nxt;
      ent_r       <= ent_nxt;
      exited_r    <= exited_nxt;
      ticks_r     <= ticks_nxt;
      run_r       <= run_nxt;
      timeout_r   <= timeout_nxt;
      head_r      <= head_nxt;
      qcnt_r      <= qcnt_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rel_err_r <= rel_err_nxt;
    out_r     <= out_nxt;
  end

  // parked rank queue
  rbs_ram #(
    .WIDTH (QA_W),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .wr_en   (q_we),
    .wr_addr (head_r + qcnt_r[QA_W-1:0]),
    .wr_data (in_data.rank[QA_W-1:0]),
    .rd_en   (cmd.rd),
    .rd_addr (head_r),
    .rd_data (q_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_timer_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> ticks_r != '0)
    else $error("timer running with no ticks left");
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= PCNT_W'(QDEPTH))
    else $error("parked queue overfilled");
  a_pop_shows_beat: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> out_valid_r)
    else $error("released rank did not reach the output");
`endif

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none

module tb;
  import rbs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS  = 500;

  typedef out_t out_q_t[$];

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [PEND_W-1:0]    val;
    in_t                  item;
    bit                   known;
    out_t                 res;
  } row_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  in_t                  in_data   = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PEND_W-1:0]    cfg_data  = '0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 cfg_ready;
  out_t                 out_data;

  logic [PEND_W-1:0] part_mask  = '0;
  logic [PEND_W-1:0] pend_set   = '0;
  logic [TICK_W-1:0] tmo_ticks  = '0;
  logic [TICK_W-1:0] ticks_left = '0;
  int                entered    = 0;
  bit                exited     = 1'b0;
  bit                timing     = 1'b0;
  logic [QA_W-1:0]   parked[$];
  out_t              answers[$];
  int                errors     = 0;
  int                beats_seen = 0;
  int                offered    = 0;
  bit                sender_burst = 1'b0;

  rank_barrier_sync u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic out_t barrier_result(kind_t k, logic [RANK_W-1:0] w);
    out_t r;
    r.kind          = k;
    r.who           = w;
    r.pending_mask  = pend_set;
    r.pending_count = CNT_W'($countones(pend_set));
    r.total_count   = CNT_W'($countones(part_mask & RANK_SPACE));
    r.last          = 1'b0;
    return r;
  endfunction

  function automatic out_q_t release_parked(kind_t k);
    out_q_t res;
    while (parked.size() != 0) begin
      res.push_back(barrier_result(k, RANK_W'(parked.pop_front())));
    end
    return res;
  endfunction

  function automatic void reload_barrier();
    pend_set   = part_mask & RANK_SPACE;
    entered    = 0;
    parked.delete();
    exited     = 1'b0;
    ticks_left = '0;
    timing     = 1'b0;
  endfunction

  function automatic out_q_t step_barrier(in_t it);
    out_q_t res;
    int total;
    total = $countones(part_mask & RANK_SPACE);
    case (it.func)
      FN_ENTER: begin
        if (it.rank >= NRANKS || !pend_set[it.rank[QA_W-1:0]]) begin
          res.push_back(barrier_result(K_REJ, it.rank));
        end else begin
          pend_set[it.rank[QA_W-1:0]] = 1'b0;
          if (entered < QDEPTH) entered++;
          if (exited) begin
            res.push_back(barrier_result(K_AFTER, it.rank));
          end else begin
            if (parked.size() < QDEPTH) parked.push_back(it.rank[QA_W-1:0]);
            if (entered == total) begin
              res        = release_parked(K_OK);
              timing     = 1'b0;
              ticks_left = '0;
            end else if (entered == 1 && tmo_ticks != 0) begin
              ticks_left = tmo_ticks;
              timing     = 1'b1;
            end
          end
        end
      end
      FN_EXIT: begin
        exited = 1'b1;
        res    = release_parked(K_ERR);
      end
      FN_TICK: begin
        if (timing) begin
          if (ticks_left != 0) ticks_left--;
          if (ticks_left == 0) begin
            timing = 1'b0;
            res.push_back(barrier_result(K_TMO, '0));
          end
        end
      end
      FN_ABORT: begin
        res        = release_parked(K_ERR);
        timing     = 1'b0;
        ticks_left = '0;
      end
    endcase
    if (res.size() != 0) res[res.size()-1].last = 1'b1;
    return res;
  endfunction

  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [PEND_W-1:0] val);
    row_t r;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    r.item   = '0;
    r.known  = 1'b0;
    r.res    = '0;
    return r;
  endfunction

  function automatic row_t item_row(func_t f, logic [RANK_W-1:0] rk);
    row_t r;
    r.is_cfg    = 1'b0;
    r.idx       = '0;
    r.val       = '0;
    r.item.func = f;
    r.item.rank = rk;
    r.known     = 1'b0;
    r.res       = '0;
    return r;
  endfunction

  function automatic row_t known_row(func_t f, logic [RANK_W-1:0] rk, kind_t k,
                                     logic [RANK_W-1:0] w, logic [PEND_W-1:0] pm,
                                     int pc, int tc);
    row_t r;
    r = item_row(f, rk);
    r.known             = 1'b1;
    r.res.kind          = k;
    r.res.who           = w;
    r.res.pending_mask  = pm;
    r.res.pending_count = CNT_W'(pc);
    r.res.total_count   = CNT_W'(tc);
    r.res.last          = 1'b1;
    return r;
  endfunction

  task automatic send_beat(in_t it, bit settle, bit known, out_t res);
    int g;
    out_q_t got;
    g = pick_gap(sender_burst);
    if (settle && g == 0) g = 1;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
      while (settle && answers.size() != 0) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = step_barrier(it);
    if (known) begin
      answers.push_back(res);
    end else begin
      foreach (got[i]) answers.push_back(got[i]);
    end
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PEND_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_MASK) begin
      part_mask = val;
      reload_barrier();
    end else if (idx == CFG_TIMEOUT) begin
      tmo_ticks = val[TICK_W-1:0];
    end
  endtask

  task automatic run_phase();
    logic [PEND_W-1:0] m;
    logic [TICK_W-1:0] t;
    logic [QA_W-1:0]   order[$];
    logic [QA_W-1:0]   done[$];
    logic [QA_W-1:0]   swap;
    in_t               it;
    int                sel;
    int                j;
    bit                settle;
    sel = $urandom_range(0, 19);
    case (sel)
      0:              m = '1;
      1:              m = '0;
      2:              m = PEND_W'(1) << $urandom_range(0, PEND_W - 1);
      16, 17, 18, 19: m = {$urandom, $urandom};
      default:        m = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    endcase
    sel = $urandom_range(0, 9);
    if (sel < 3) t = '0;
    else if (sel < 8) t = $urandom_range(1, 4 + $countones(m));
    else if (sel == 8) t = '1;
    else t = $urandom;

    settle_block();
    write_reg(CFG_MASK, m);
    if ($urandom_range(0, 4) != 0) write_reg(CFG_TIMEOUT, PEND_W'(t));
    if ($urandom_range(0, 9) == 0) write_reg(CFG_SPARE, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    sender_burst = ($urandom_range(0, 3) == 0);

    for (int i = 0; i < NRANKS; i++) begin
      if (m[i]) order.push_back(QA_W'(i));
    end
    for (int i = order.size() - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      swap     = order[i];
      order[i] = order[j];
      order[j] = swap;
    end

    while (order.size() != 0) begin
      sel     = $urandom_range(0, 99);
      settle  = ($urandom_range(0, 49) == 0);
      it.rank = RANK_W'($urandom_range(0, 255));
      if (sel < 25) begin
        it.func = FN_TICK;
      end else if (sel < 31) begin
        it.func = FN_ENTER;
      end else if (sel < 34 && done.size() != 0) begin
        it.func = FN_ENTER;
        it.rank = RANK_W'(done[$urandom_range(0, done.size() - 1)]);
      end else if (sel < 36) begin
        it.func = FN_EXIT;
      end else if (sel < 38) begin
        it.func = FN_ABORT;
      end else begin
        it.func = FN_ENTER;
        it.rank = RANK_W'(order[0]);
        done.push_back(order.pop_front());
      end
      send_beat(it, settle, 1'b0, '0);
      offered++;
    end
    repeat ($urandom_range(0, 3)) begin
      it.func = func_t'($urandom_range(0, 3));
      it.rank = RANK_W'($urandom_range(0, 255));
      send_beat(it, 1'b0, 1'b0, '0);
      offered++;
    end
  endtask

  task automatic check_field(string name, logic [PEND_W-1:0] e, logic [PEND_W-1:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      errors++;
    end
  endtask

  // result side: random stalls, one long hold-off once traffic is flowing
  initial begin
    int   g;
    bit   rx_burst;
    bit   held;
    out_t exp_res;
    rx_burst = 1'b0;
    held     = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && beats_seen >= 40) begin
        held = 1'b1;
        g    = 400;
      end else begin
        g = pick_gap(rx_burst);
      end
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (answers.size() == 0) begin
        $error("result beat with nothing expected: kind %0d, who %0d",
               out_data.kind, out_data.who);
        errors++;
      end else begin
        exp_res = answers.pop_front();
        check_field("kind", PEND_W'(exp_res.kind), PEND_W'(out_data.kind));
        check_field("who", PEND_W'(exp_res.who), PEND_W'(out_data.who));
        check_field("pending_mask", exp_res.pending_mask, out_data.pending_mask);
        check_field("pending_count", PEND_W'(exp_res.pending_count),
                    PEND_W'(out_data.pending_count));
        check_field("total_count", PEND_W'(exp_res.total_count),
                    PEND_W'(out_data.total_count));
        check_field("last", PEND_W'(exp_res.last), PEND_W'(out_data.last));
      end
      beats_seen++;
      if (beats_seen % 64 == 0) rx_burst = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    row_t rows[$];
    rows.push_back(known_row(FN_ENTER, 8'd0, K_REJ, 8'd0, '0, 0, 0));
    rows.push_back(known_row(FN_ENTER, 8'hFF, K_REJ, 8'hFF, '0, 0, 0));
    rows.push_back(item_row(FN_TICK, 8'hAA));
    rows.push_back(item_row(FN_ABORT, 8'd0));
    rows.push_back(item_row(FN_EXIT, 8'h55));
    rows.push_back(cfg_row(CFG_MASK, '1));
    rows.push_back(cfg_row(CFG_TIMEOUT, 64'hFFFF_FFFF));
    rows.push_back(cfg_row(CFG_SPARE, '1));
    rows.push_back(known_row(FN_ENTER, 8'd64, K_REJ, 8'd64, '1, 64, 64));
    rows.push_back(item_row(FN_ENTER, 8'd63));
    rows.push_back(known_row(FN_ENTER, 8'd63, K_REJ, 8'd63, 64'h7FFF_FFFF_FFFF_FFFF, 63, 64));
    rows.push_back(item_row(FN_ENTER, 8'd0));
    rows.push_back(item_row(FN_TICK, 8'd0));
    rows.push_back(item_row(FN_EXIT, 8'd0));
    rows.push_back(item_row(FN_ENTER, 8'd5));
    rows.push_back(item_row(FN_ABORT, 8'd0));
    rows.push_back(cfg_row(CFG_MASK, 64'h5));
    rows.push_back(cfg_row(CFG_TIMEOUT, 64'd2));
    rows.push_back(item_row(FN_ENTER, 8'd0));
    rows.push_back(item_row(FN_TICK, 8'd0));
    rows.push_back(item_row(FN_TICK, 8'd0));
    rows.push_back(item_row(FN_ENTER, 8'd1));
    rows.push_back(item_row(FN_ENTER, 8'd2));
    rows.push_back(cfg_row(CFG_MASK, 64'h8000_0000_0000_0001));
    rows.push_back(cfg_row(CFG_TIMEOUT, 64'd0));
    rows.push_back(item_row(FN_ENTER, 8'd63));
    rows.push_back(item_row(FN_TICK, 8'd0));
    rows.push_back(item_row(FN_ENTER, 8'd0));

    reload_barrier();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        if (i == 0 || !rows[i-1].is_cfg) settle_block();
        write_reg(rows[i].idx, rows[i].val);
        if (i + 1 == rows.size() || !rows[i+1].is_cfg) cfg_valid <= 1'b0;
      end else begin
        send_beat(rows[i].item, 1'b0, rows[i].known, rows[i].res);
      end
    end

    while (offered < RANDOM_ITEMS) run_phase();

    in_valid <= 1'b0;
    while (answers.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== rank_barrier_sync.f =====
hdl/rbs_pkg.sv
hdl/rbs_ram.sv
hdl/rbs_ctrl.sv
hdl/rbs_dp.sv
hdl/rank_barrier_sync.sv
bench/tb.sv
